### rtl/core/crq_pkg.sv
// shared types and codes for the cascaded ring queues block
`timescale 1ns / 1ps

package crq_pkg;

  // action field codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted input beat
    logic exec;     // run the selected queue operation
    logic load_rd;  // move the dequeued element into the output register
  } crq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a new beat this cycle
    logic deq_hit;   // pending item is a dequeue that found a non-empty queue
  } crq_stat_t;

endpackage

### rtl/core/crq_ifs.sv
// valid/ready channel interfaces for the input and result streams
`timescale 1ns / 1ps

interface crq_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface crq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [1:0]         queue_index;

  modport source (output valid, output status, output data, output queue_index, input ready);
  modport sink   (input valid, input status, input data, input queue_index, output ready);
endinterface

### rtl/core/crq_controller.sv
// sequencing state machine for the cascaded ring queues
`timescale 1ns / 1ps

module crq_controller import crq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  crq_stat_t stat,
  output crq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  // command decode per state
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.capture = in_valid;
      S_EXEC: cmd.exec    = stat.out_free | stat.deq_hit;
      S_READ: cmd.load_rd = stat.out_free;
      default: cmd = '0;
    endcase
  end

  // state and ready register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_EXEC;
            in_ready_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (stat.deq_hit) begin
            state_r <= S_READ;
          end else if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_READ: begin
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

### rtl/core/crq_datapath.sv
// queue storage, pointers, fill counts and output register
`timescale 1ns / 1ps

module crq_datapath import crq_pkg::*; #(
  parameter int NUM_QUEUES = 3,
  parameter int DEPTH      = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  crq_cmd_t           cmd,
  output crq_stat_t          stat,
  input  logic               in_action,
  input  logic signed [31:0] in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic [1:0]         out_queue_index
);

  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int AW  = $clog2(NUM_QUEUES * DEPTH);
  localparam int MEM_WORDS = NUM_QUEUES * DEPTH;

  // queue number masked to the two bit result field
  function automatic logic [1:0] qidx2(input logic [QIW-1:0] q);
    logic [QIW+1:0] w;
    w = {2'b00, q};
    return w[1:0];
  endfunction

  logic                  act_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [QIW-1:0]        q_r;
  logic [PW-1:0]         head_r [NUM_QUEUES];
  logic [PW-1:0]         tail_r [NUM_QUEUES];
  logic [CW-1:0]         cnt_r  [NUM_QUEUES];
  logic [DATA_WIDTH-1:0] mem    [MEM_WORDS];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic signed [31:0]    out_data_r;
  logic [1:0]            out_qidx_r;

  logic                  found;
  logic [QIW-1:0]        sel;
  logic [PW-1:0]         ptr;
  logic [PW-1:0]         ptr_nxt;
  logic [AW-1:0]         addr;
  logic                  op_hit;

  // input beat capture, value kept at storage width
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      val_r <= DATA_WIDTH'(in_value);
    end
  end

  // lowest-numbered queue that can take or give an element
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if ((act_r == ACT_ENQ) ? (cnt_r[q] != CW'(DEPTH)) : (cnt_r[q] != '0)) begin
        found = 1'b1;
        sel   = QIW'(q);
      end
    end
  end

  // slot pointer of the chosen queue and its wrapped successor
  always_comb begin
    ptr = '0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (QIW'(q) == sel) begin
        ptr = (act_r == ACT_DEQ) ? head_r[q] : tail_r[q];
      end
    end
  end

  assign ptr_nxt = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign addr    = AW'(sel) * AW'(DEPTH) + AW'(ptr);
  assign op_hit  = cmd.exec & found;

  assign stat.out_free = ~out_valid_r | out_ready;
  assign stat.deq_hit  = (act_r == ACT_DEQ) & found;

  // pointer and fill count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        cnt_r[q]  <= '0;
      end
    end else if (op_hit) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (QIW'(q) == sel) begin
          if (act_r == ACT_ENQ) begin
            tail_r[q] <= ptr_nxt;
            cnt_r[q]  <= cnt_r[q] + 1'b1;
          end else begin
            head_r[q] <= ptr_nxt;
            cnt_r[q]  <= cnt_r[q] - 1'b1;
          end
        end
      end
    end
  end

  // element storage, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (op_hit && act_r == ACT_ENQ) begin
      mem[addr] <= val_r;
    end
    if (op_hit && act_r == ACT_DEQ) begin
      rd_data_r <= mem[addr];
    end
  end

  // queue of the pending dequeue
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      q_r <= sel;
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.exec && !stat.deq_hit) || cmd.load_rd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      out_status_r <= ST_DEQ;
      out_data_r   <= 32'(rd_data_r);
      out_qidx_r   <= qidx2(q_r);
    end else if (cmd.exec && !stat.deq_hit) begin
      out_data_r <= '0;
      if (found) begin
        out_status_r <= ST_ENQ;
        out_qidx_r   <= qidx2(sel);
      end else begin
        out_status_r <= (act_r == ACT_ENQ) ? ST_FULL : ST_EMPTY;
        out_qidx_r   <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data        = out_data_r;
  assign out_queue_index = out_qidx_r;

endmodule

### rtl/core/cascaded_ring_queues_unit.sv
// top level of the cascaded ring queues: controller, datapath and checks
// order: enqueue, full and empty results are loaded into the output register in the exec step;
//   a dequeue result that finds an element is loaded in a separate read step after the registered storage read
// sequencing: the state machine handles one beat at a time around the single storage
//   port and takes no new beat until the result is loaded; a waiting result stalls the
//   step that loads the output register and so also holds off the next input beat
// reset: pointers, fill counts and control clear at the first clock edge with rst_n low;
//   element storage is not cleared
`timescale 1ns / 1ps

module cascaded_ring_queues_unit import crq_pkg::*; #(
  parameter int NUM_QUEUES = 3,
  parameter int DEPTH      = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  crq_in_if.sink    in_ch,
  crq_out_if.source out_ch
);

  crq_cmd_t  cmd;
  crq_stat_t stat;

  // sequencing
  crq_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  crq_datapath #(
    .NUM_QUEUES (NUM_QUEUES),
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_ch.action),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_data        (out_ch.data),
    .out_queue_index (out_ch.queue_index)
  );

`ifndef SYNTHESIS
  // one beat in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is still in flight");

  // a dequeued element only moves into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_rd |-> stat.out_free)
    else $error("dequeue result loaded over a pending output beat");

  // a dequeue that hit a queue is followed by its read step, not a new beat
  a_deq_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && stat.deq_hit) |=> (!in_ch.ready && !cmd.exec))
    else $error("dequeue read step skipped");
`endif

endmodule

### tb/crq_queue_checker.sv
// result checker for the cascaded ring queues: watches both channels, predicts and compares
`timescale 1ns / 1ps

module crq_queue_checker import crq_pkg::*; #(
  parameter int NUM_QUEUES = 3,
  parameter int DEPTH      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  crq_in_if           in_ch,
  crq_out_if          out_ch,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data;
    logic [1:0]         queue_index;
  } queue_result_t;

  // shadow copy of the queues
  logic signed [31:0] ring_slots [NUM_QUEUES][DEPTH];
  int unsigned        head_slot  [NUM_QUEUES];
  int unsigned        tail_slot  [NUM_QUEUES];
  int unsigned        fill_level [NUM_QUEUES];

  queue_result_t expected_results [$];
  int unsigned   bad_results = 0;
  int unsigned   owed = 0;

  assign mismatch_count = bad_results;
  assign results_owed   = owed;

  // apply one operation to the shadow queues and return what the block should answer
  function automatic queue_result_t predict_queue_op(logic action, logic signed [31:0] value);
    queue_result_t res;
    res.data        = '0;
    res.queue_index = '0;
    if (action == ACT_ENQ) begin
      res.status = ST_FULL;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (fill_level[q] < DEPTH) begin
          ring_slots[q][tail_slot[q]] = value;
          tail_slot[q] = (tail_slot[q] + 1 == DEPTH) ? 0 : tail_slot[q] + 1;
          fill_level[q]++;
          res.status      = ST_ENQ;
          res.queue_index = 2'(q);
          return res;
        end
      end
    end else begin
      res.status = ST_EMPTY;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (fill_level[q] != 0) begin
          res.data = ring_slots[q][head_slot[q]];
          head_slot[q] = (head_slot[q] + 1 == DEPTH) ? 0 : head_slot[q] + 1;
          fill_level[q]--;
          res.status      = ST_DEQ;
          res.queue_index = 2'(q);
          return res;
        end
      end
    end
    return res;
  endfunction

  // compare result beats first, then queue the prediction for an input beat
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_slot[q]  = 0;
        tail_slot[q]  = 0;
        fill_level[q] = 0;
      end
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t unexpected result beat: status %0d data %h queue %0d",
                     $realtime, out_ch.status, out_ch.data, out_ch.queue_index);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status || out_ch.data !== want.data ||
              out_ch.queue_index !== want.queue_index) begin
            bad_results++;
            if (bad_results <= 10)
              $display("%0t result mismatch: expected status %0d data %h queue %0d, got status %0d data %h queue %0d",
                       $realtime, want.status, want.data, want.queue_index,
                       out_ch.status, out_ch.data, out_ch.queue_index);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_queue_op(in_ch.action, in_ch.value));
    end
    owed = expected_results.size();
  end

endmodule

### tb/cascaded_ring_queues_unit_tb.sv
// testbench top for the cascaded ring queues: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module cascaded_ring_queues_unit_tb import crq_pkg::*;;

  localparam int NUM_QUEUES    = 3;
  localparam int DEPTH         = 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int SEGMENTS      = 25;
  localparam int SEGMENT_ITEMS = 40;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned quiet_cycles = 0;

  crq_in_if  in_ch ();
  crq_out_if out_ch ();

  cascaded_ring_queues_unit #(
    .NUM_QUEUES(NUM_QUEUES),
    .DEPTH     (DEPTH),
    .DATA_WIDTH(32)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  crq_queue_checker #(
    .NUM_QUEUES(NUM_QUEUES),
    .DEPTH     (DEPTH)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // present one beat at the falling edge and hold it until taken, return at the next falling edge
  task automatic push_beat(logic action, logic signed [31:0] value);
    in_ch.valid  <= 1'b1;
    in_ch.action <= action;
    in_ch.value  <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // sender gap with valid held low
  task automatic hold_off(int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    hold_off(1);
    while (results_owed != 0) @(negedge clk);
  endtask

  // random operations in bursts, enqueue share given in percent
  task automatic send_random(int unsigned count, int unsigned enq_pct, bit with_gaps);
    int unsigned burst_left;
    burst_left = $urandom_range(1, 24);
    repeat (count) begin
      push_beat(($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ, $urandom);
      burst_left--;
      if (burst_left == 0) begin
        if (with_gaps) hold_off($urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // receiver: always ready, coin flip, or runs of stalls, switching now and then
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned run_left;
    logic        run_ready;
    out_ch.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    run_left  = 0;
    run_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (run_left == 0) begin
            run_ready = !run_ready;
            run_left  = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 12);
          end
          run_left--;
          out_ch.ready <= run_ready;
        end
      endcase
    end
  end

  // end the run when no beat moves on either channel for too long
  initial begin : watchdog
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    logic signed [31:0] corner_values [12];
    int unsigned        enq_mix [5];
    corner_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
                      32'sh0000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shFFFF_0000,
                      32'sh0000_FFFF, 32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh1234_5678};
    enq_mix = '{90, 75, 50, 25, 10};
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_ENQ;
    in_ch.value  = '0;

    // synchronous reset, released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // dequeue with every queue empty
    push_beat(ACT_DEQ, 32'shDEAD_BEEF);
    // fill all three queues with extreme values, tail pointers wrap
    foreach (corner_values[i]) push_beat(ACT_ENQ, corner_values[i]);
    // every queue full, value dropped
    push_beat(ACT_ENQ, 32'sh0BAD_F00D);
    // empty queue 0 completely so its head wraps, then take one from queue 1
    repeat (5) push_beat(ACT_DEQ, $urandom);
    // enqueue goes back to queue 0 ahead of the lower ranks
    push_beat(ACT_ENQ, 32'sh7FFF_FFFF);
    push_beat(ACT_ENQ, 32'sh8000_0000);
    push_beat(ACT_DEQ, 32'shFFFF_FFFF);
    drain_results();

    // random segments with shifting enqueue share, some without sender gaps
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_random(SEGMENT_ITEMS, enq_mix[$urandom_range(0, 4)], $urandom_range(0, 3) != 0);
      if (seg == SEGMENTS / 2) drain_results();
    end

    // wait for the tail of the results, then wait quietly for stray result beats
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
